@@ rtl/osu_pkg.sv @@
// Package for the ordered integer set unit.
// Holds the set geometry, the request codes, the controller/datapath
// handshake structs and the bit-search helper functions. No dependencies.
package osu_pkg;

  // Set geometry: keys 0 .. UNIVERSE-1 in NUM_WORDS member words.
  localparam int UNIVERSE  = 1024;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = (UNIVERSE + WORD_BITS - 1) / WORD_BITS;
  localparam int KEY_W     = 10;
  localparam int RES_W     = 11;
  localparam int CNT_W     = 11;
  localparam int REQ_W     = 3;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = $clog2(NUM_WORDS);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUCC    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MIN     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_MIN = 3'd4;

  // Key value that means "no member".
  localparam logic [RES_W-1:0] NO_KEY = RES_W'(UNIVERSE);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [NUM_WORDS-1:0] summary_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take in a request and pick the first word to read
    logic read;     // read the member word at the current word address
    logic eval;     // evaluate the word, update state, load the result
    logic second;   // evaluation of the follow-up word of a successor search
  } osu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_next;  // successor must continue in a later word
    logic out_free;   // result register can take a new result this cycle
  } osu_status_t;

  // Index of the lowest set bit of a member word; zero when the word is empty.
  function automatic logic [BIT_W-1:0] lowest_bit(input word_t value);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (value[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Index of the lowest non-empty word in a summary; zero when none is set.
  function automatic logic [WADDR_W-1:0] lowest_word(input summary_t value);
    logic [WADDR_W-1:0] idx;
    idx = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (value[i]) idx = WADDR_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ rtl/osu_if.sv @@
// Valid/ready channel interfaces for the ordered integer set unit.
// osu_req_if carries requests, osu_rsp_if carries results. Depends on osu_pkg.
interface osu_req_if;
  logic                         valid;
  logic                         ready;
  logic [osu_pkg::REQ_W-1:0]    req_type;
  logic [osu_pkg::KEY_W-1:0]    key;

  modport source (output valid, req_type, key, input ready);
  modport sink   (input valid, req_type, key, output ready);
endinterface

interface osu_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [osu_pkg::RES_W-1:0]    result_key;
  logic                         found;
  logic [osu_pkg::CNT_W-1:0]    member_count;

  modport source (output valid, result_key, found, member_count, input ready);
  modport sink   (input valid, result_key, found, member_count, output ready);
endinterface

@@ rtl/osu_ctrl.sv @@
// Controller state machine of the ordered integer set unit.
// Sequences capture, word read and evaluation; uses osu_pkg structs.
module osu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  osu_pkg::osu_status_t  status,
  output osu_pkg::osu_cmd_t     cmd
);
  import osu_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_READ2 = 3'd3;
  localparam logic [2:0] ST_EVAL2 = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    req_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        // Evaluation waits until the result register has room.
        if (status.out_free) begin
          cmd.eval   = 1'b1;
          state_next = status.need_next ? ST_READ2 : ST_IDLE;
        end
      end
      ST_READ2: begin
        cmd.read   = 1'b1;
        state_next = ST_EVAL2;
      end
      ST_EVAL2: begin
        if (status.out_free) begin
          cmd.eval   = 1'b1;
          cmd.second = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted request always goes on to a word read.
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_READ))
    else $error("accepted request did not move to the read state");

  // A successor search continues in at most one further word.
  a_single_follow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL2 && cmd.eval) |=> (state == ST_IDLE))
    else $error("second evaluation did not finish the request");

endmodule

@@ rtl/osu_datapath.sv @@
// Datapath of the ordered integer set unit: member word memory, summary
// word, member count, evaluation logic and the result register. Uses osu_pkg.
module osu_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [osu_pkg::REQ_W-1:0]   req_type,
  input  logic [osu_pkg::KEY_W-1:0]   key,
  input  osu_pkg::osu_cmd_t           cmd,
  output osu_pkg::osu_status_t        status,
  input  logic                        rsp_ready,
  output logic                        rsp_valid,
  output logic [osu_pkg::RES_W-1:0]   result_key,
  output logic                        found,
  output logic [osu_pkg::CNT_W-1:0]   member_count
);
  import osu_pkg::*;

  // Member words; a word whose summary bit is clear reads as empty.
  word_t mem [NUM_WORDS];

  logic [REQ_W-1:0]   req_q;
  logic [KEY_W-1:0]   key_q;
  logic [WADDR_W-1:0] word_addr;
  word_t              rd_word;
  logic               rd_live;
  summary_t           summary;
  logic [CNT_W-1:0]   count;

  word_t              word_eff;
  word_t              word_new;
  word_t              onehot;
  word_t              upper;
  logic [BIT_W-1:0]   bit_sel;
  logic               is_member;
  logic               is_min_op;
  logic               wr_en;
  summary_t           next_mask;
  logic [WADDR_W-1:0] next_addr;
  logic [CNT_W-1:0]   count_next;
  logic [RES_W-1:0]   res_key;
  logic               res_found;

  assign is_min_op = (req_type == REQ_MIN) || (req_type == REQ_POP_MIN);

  // Request capture and word address selection.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q     <= req_type;
      key_q     <= key;
      word_addr <= is_min_op ? lowest_word(summary) : key[KEY_W-1:BIT_W];
    end else if (cmd.eval && status.need_next) begin
      word_addr <= next_addr;
    end
  end

  // Registered word read.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_word <= mem[word_addr];
      rd_live <= summary[word_addr];
    end
  end

  // Word write-back.
  always_ff @(posedge clk) begin
    if (cmd.eval && wr_en) begin
      mem[word_addr] <= word_new;
    end
  end

  // Word evaluation.
  always_comb begin
    word_eff   = rd_live ? rd_word : '0;
    bit_sel    = ((req_q == REQ_MIN) || (req_q == REQ_POP_MIN)) ?
                 lowest_bit(word_eff) : key_q[BIT_W-1:0];
    onehot     = word_t'(1) << bit_sel;
    is_member  = |(word_eff & onehot);
    upper      = word_eff & (({WORD_BITS{1'b1}} << bit_sel) << 1);
    next_mask  = summary & (({NUM_WORDS{1'b1}} << word_addr) << 1);
    next_addr  = lowest_word(next_mask);

    wr_en      = 1'b0;
    word_new   = word_eff;
    count_next = count;
    res_key    = NO_KEY;
    res_found  = 1'b0;
    status.need_next = 1'b0;

    case (req_q)
      REQ_INSERT: begin
        if (!is_member) begin
          wr_en      = 1'b1;
          word_new   = word_eff | onehot;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (is_member) begin
          wr_en      = 1'b1;
          word_new   = word_eff & ~onehot;
          count_next = count - CNT_W'(1);
        end
      end
      REQ_SUCC: begin
        if (cmd.second) begin
          res_key   = RES_W'({word_addr, lowest_bit(word_eff)});
          res_found = 1'b1;
        end else if (|upper) begin
          res_key   = RES_W'({word_addr, lowest_bit(upper)});
          res_found = 1'b1;
        end else begin
          status.need_next = |next_mask;
        end
      end
      REQ_MIN: begin
        if (rd_live) begin
          res_key   = RES_W'({word_addr, bit_sel});
          res_found = 1'b1;
        end
      end
      REQ_POP_MIN: begin
        if (rd_live) begin
          res_key    = RES_W'({word_addr, bit_sel});
          res_found  = 1'b1;
          wr_en      = 1'b1;
          word_new   = word_eff & ~onehot;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    status.out_free = !rsp_valid || rsp_ready;
  end

  // Summary word and member count.
  always_ff @(posedge clk) begin
    if (rst) begin
      summary <= '0;
      count   <= '0;
    end else if (cmd.eval) begin
      if (wr_en) summary[word_addr] <= |word_new;
      count <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.eval && !status.need_next) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && !status.need_next) begin
      result_key   <= res_key;
      found        <= res_found;
      member_count <= count_next;
    end
  end

  // The count is zero exactly when no word is marked non-empty.
  a_count_summary: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (summary == '0))
    else $error("member count disagrees with the summary word");

  // The count never passes the size of the universe.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(UNIVERSE))
    else $error("member count beyond universe");

  // A found result always names a real key.
  a_found_key: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && found) |-> (result_key < NO_KEY))
    else $error("found result carries an out-of-range key");

  // A finished evaluation presents its result in the next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && !status.need_next) |=> rsp_valid)
    else $error("evaluated request produced no result");

endmodule

@@ rtl/ordered_integer_set_unit.sv @@
// Top level of the ordered integer set unit.
// Joins osu_ctrl and osu_datapath to the request and result channels
// (osu_req_if, osu_rsp_if); uses osu_pkg.
//
// Keeps a set of keys 0..1023 as sixteen 64-bit member words plus a 16-bit
// summary of non-empty words, and serves insert, remove, successor, find-min
// and remove-min requests with one result each (result_key 1024 and found 0
// mean no member). A request is answered after one member word visit for
// every type except a successor whose answer lies outside the key's own word,
// which visits a second word: each member word visit is one registered memory
// read followed by an evaluate/write-back step on the single word memory
// port. A new request is taken only after the previous one has been evaluated,
// but the result register lets it be accepted while the previous result still
// waits to be taken. The set is empty after reset, with no clearing pass.
module ordered_integer_set_unit (
  input  logic   clk,
  input  logic   rst,
  osu_req_if.sink   req,
  osu_rsp_if.source rsp
);
  import osu_pkg::*;

  osu_cmd_t    cmd;
  osu_status_t status;

  osu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  osu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req_type     (req.req_type),
    .key          (req.key),
    .cmd          (cmd),
    .status       (status),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .result_key   (rsp.result_key),
    .found        (rsp.found),
    .member_count (rsp.member_count)
  );

endmodule

@@ verif/osu_set_checker.sv @@
// Checker for the ordered integer set unit: keeps its own copy of the set,
// predicts one answer per accepted request and compares each result transfer.
// Depends on osu_pkg; instantiated by tb_top beside the block.
module osu_set_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic                      req_ready,
  input  logic [osu_pkg::REQ_W-1:0] req_type,
  input  logic [osu_pkg::KEY_W-1:0] req_key,
  input  logic                      rsp_valid,
  input  logic                      rsp_ready,
  input  logic [osu_pkg::RES_W-1:0] rsp_key,
  input  logic                      rsp_found,
  input  logic [osu_pkg::CNT_W-1:0] rsp_count,
  output int                        error_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import osu_pkg::*;

  typedef struct packed {
    logic [RES_W-1:0] result_key;
    logic             found;
    logic [CNT_W-1:0] member_count;
  } set_answer_t;

  // Flat membership map of the whole universe and the number of members.
  bit [UNIVERSE-1:0] member_map;
  int                population;
  set_answer_t       answer_queue[$];

  initial begin
    error_count = 0;
    pending     = 0;
    member_map  = '0;
    population  = 0;
  end

  task automatic flag_error(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Smallest member at or above start, or UNIVERSE when there is none.
  function automatic int lowest_member_from(input int start);
    for (int i = start; i < UNIVERSE; i++) begin
      if (member_map[i]) return i;
    end
    return UNIVERSE;
  endfunction

  // Applies one request to the set and returns the answer it must produce.
  function automatic set_answer_t apply_request(input logic [REQ_W-1:0] op,
                                                input logic [KEY_W-1:0] k);
    set_answer_t answer;
    int          hit;
    hit = UNIVERSE;
    case (op)
      REQ_INSERT: begin
        if (!member_map[k]) begin
          member_map[k] = 1'b1;
          population++;
        end
      end
      REQ_REMOVE: begin
        if (member_map[k]) begin
          member_map[k] = 1'b0;
          population--;
        end
      end
      REQ_SUCC: begin
        hit = (int'(k) >= UNIVERSE - 1) ? UNIVERSE : lowest_member_from(int'(k) + 1);
      end
      REQ_MIN: begin
        hit = lowest_member_from(0);
      end
      REQ_POP_MIN: begin
        hit = lowest_member_from(0);
        if (hit < UNIVERSE) begin
          member_map[hit] = 1'b0;
          population--;
        end
      end
      default: begin
      end
    endcase
    answer.result_key   = RES_W'(hit);
    answer.found        = (hit < UNIVERSE);
    answer.member_count = CNT_W'(population);
    return answer;
  endfunction

  // Results are retired before the request of the same edge is predicted,
  // since a request never answers on the edge it is taken.
  always @(posedge clk) begin : watch
    set_answer_t want;
    if (rst) begin
      member_map = '0;
      population = 0;
      answer_queue.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (answer_queue.size() == 0) begin
          flag_error($sformatf("result transfer key=%0d found=%0b count=%0d with none due",
                               rsp_key, rsp_found, rsp_count));
        end else begin
          want = answer_queue.pop_front();
          if (rsp_key !== want.result_key)
            flag_error($sformatf("result_key %0d, want %0d", rsp_key, want.result_key));
          if (rsp_found !== want.found)
            flag_error($sformatf("found %0b, want %0b", rsp_found, want.found));
          if (rsp_count !== want.member_count)
            flag_error($sformatf("member_count %0d, want %0d", rsp_count,
                                 want.member_count));
        end
      end
      if (req_valid && req_ready) begin
        answer_queue.push_back(apply_request(req_type, req_key));
      end
    end
    pending = answer_queue.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Top of the ordered integer set unit testbench: clock, reset, request
// stimulus with bursts and gaps, result-side stalls, watchdog and verdict.
// Depends on osu_pkg, osu_if, ordered_integer_set_unit and osu_set_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import osu_pkg::*;

  // Request codes the block must answer with "none" and leave the set alone.
  localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 1225;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;

  logic clk;
  logic rst;
  int   error_count;
  int   pending;
  int   quiet_cycles;

  osu_req_if req_ch();
  osu_rsp_if rsp_ch();

  ordered_integer_set_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  osu_set_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_type    (req_ch.req_type),
    .req_key     (req_ch.key),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp_key     (rsp_ch.result_key),
    .rsp_found   (rsp_ch.found),
    .rsp_count   (rsp_ch.member_count),
    .error_count (error_count),
    .pending     (pending)
  );

  // Clock with an 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request and returns at the edge where it transfers.
  // Ready is looked at mid-cycle, where nothing changes.
  task automatic send_req(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key      <= k;
    do @(negedge clk); while (!req_ch.ready);
    @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Holds requests back until every outstanding result has been taken.
  // The count is looked at mid-cycle, once the checker has seen the last edge.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Keys: a mix of the whole range, a low window and word boundaries,
  // so that removes and successor searches hit members often.
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return KEY_W'($urandom_range(0, UNIVERSE - 1));
    if (sel < 7) return KEY_W'($urandom_range(0, 127));
    return KEY_W'($urandom_range(0, NUM_WORDS - 1) * WORD_BITS +
                  (($urandom_range(0, 1) == 1) ? WORD_BITS - 1 - $urandom_range(0, 1)
                                               : $urandom_range(0, 1)));
  endfunction

  function automatic logic [REQ_W-1:0] pick_op();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return REQ_INSERT;
    if (sel < 55) return REQ_REMOVE;
    if (sel < 75) return REQ_SUCC;
    if (sel < 83) return REQ_MIN;
    if (sel < 95) return REQ_POP_MIN;
    case ($urandom_range(0, 2))
      0:       return REQ_SPARE_5;
      1:       return REQ_SPARE_6;
      default: return REQ_SPARE_7;
    endcase
  endfunction

  // Result side: segments of steady, light and heavy stalling, with a long
  // hold-off early in the run and now and then later on.
  initial begin : result_side
    int segment;
    int span;
    int mode;
    rsp_ch.ready = 1'b0;
    segment = 0;
    @(posedge clk iff !rst);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 60);
      if (segment == 4 || $urandom_range(0, 15) == 0) begin
        mode = 3;
        span = $urandom_range(40, 90);
      end
      repeat (span) begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
          2:       rsp_ch.ready <= ($urandom_range(0, 9) < 3);
          default: rsp_ch.ready <= 1'b0;
        endcase
        @(posedge clk);
      end
      segment++;
    end
  end

  // Request side: reset, directed cases, then random bursts.
  initial begin : request_side
    int burst_left;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.key      = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty set: minimum, remove-minimum, remove and successor find nothing.
    send_req(REQ_MIN, 10'd0);
    send_req(REQ_POP_MIN, 10'd0);
    send_req(REQ_REMOVE, 10'd5);
    send_req(REQ_SUCC, 10'd0);
    // Extreme keys, a duplicate insert and successor of the largest key.
    send_req(REQ_INSERT, 10'd0);
    send_req(REQ_INSERT, 10'd1023);
    send_req(REQ_INSERT, 10'd0);
    send_req(REQ_SUCC, 10'd0);
    send_req(REQ_SUCC, 10'd1022);
    send_req(REQ_SUCC, 10'd1023);
    // Successor inside a word, across a word edge and across empty words.
    send_req(REQ_INSERT, 10'd63);
    send_req(REQ_INSERT, 10'd64);
    send_req(REQ_INSERT, 10'd700);
    send_req(REQ_SUCC, 10'd5);
    send_req(REQ_SUCC, 10'd63);
    send_req(REQ_REMOVE, 10'd63);
    send_req(REQ_REMOVE, 10'd64);
    send_req(REQ_SUCC, 10'd5);
    // Absent remove and the spare request codes change nothing.
    send_req(REQ_REMOVE, 10'd500);
    send_req(REQ_SPARE_5, 10'd1023);
    send_req(REQ_SPARE_6, 10'd0);
    send_req(REQ_SPARE_7, 10'd341);
    // Drain the set by remove-minimum and go one past empty.
    send_req(REQ_POP_MIN, 10'd682);
    send_req(REQ_POP_MIN, 10'd0);
    send_req(REQ_POP_MIN, 10'd1023);
    send_req(REQ_POP_MIN, 10'd0);
    settle();

    // Random part; halfway the sender waits until the results catch up.
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) settle();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
      end
      send_req(pick_op(), pick_key());
      burst_left--;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
